### hw/rtl/fu_res_pkg.sv
// Shared types, widths and the opcode-to-class table for the functional unit reserver.
// No dependencies; imported by functional_unit_reserver.
`timescale 1ns / 1ps
`default_nettype none

package fu_res_pkg;

	// pool geometry
	localparam int CLASS_COUNT     = 12;
	localparam int UNITS_PER_CLASS = 4;
	localparam int UNIT_IDX_W      = (UNITS_PER_CLASS > 1) ? $clog2(UNITS_PER_CLASS) : 1;
	localparam int ROW_IDX_W       = $clog2(CLASS_COUNT);

	// field widths
	localparam int FUNC_W   = 2;
	localparam int OPCODE_W = 6;
	localparam int CLASS_W  = 4;
	localparam int CNT_W    = 3;
	localparam int LAT_W    = 5;
	localparam int TIME_W   = 32;
	localparam int BUSY_W   = 33;
	localparam int ACC_W    = 32;
	localparam int WAIT_W   = 48;

	// configuration register widths and reset values
	localparam int UNIT_COUNTS_W = CLASS_COUNT * CNT_W;
	localparam int LATS_W        = CLASS_COUNT * LAT_W;
	localparam int CFG_IDX_W     = 2;
	localparam logic [LATS_W-1:0] LAT_RESET = 60'd37191016277640225;

	// stream payload widths, padded to whole bytes
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 152;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_RESERVE = 2'd0,
		FUNC_RELEASE = 2'd1,
		FUNC_READ    = 2'd2
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UNIT_COUNTS = 2'd0,
		REG_ISSUE_LATS  = 2'd1,
		REG_OP_LATS     = 2'd2
	} reg_idx_t;

	typedef logic [CLASS_W-1:0] class_t;

	localparam class_t CLASS_NONE      = 4'd0;
	localparam class_t CLASS_INTADD    = 4'd1;
	localparam class_t CLASS_INTSUB    = 4'd2;
	localparam class_t CLASS_INTMULT   = 4'd3;
	localparam class_t CLASS_INTDIV    = 4'd4;
	localparam class_t CLASS_EFFADDR   = 4'd5;
	localparam class_t CLASS_LOGIC     = 4'd6;
	localparam class_t CLASS_FPSIMPLE  = 4'd7;
	localparam class_t CLASS_FPADD     = 4'd8;
	localparam class_t CLASS_FPCOMP    = 4'd9;
	localparam class_t CLASS_FPMULT    = 4'd10;
	localparam class_t CLASS_FPDIV     = 4'd11;
	localparam class_t CLASS_FPCOMPLEX = 4'd12;

	// opcode to unit class; opcodes not in the table need no unit
	function automatic class_t op_class(input logic [OPCODE_W-1:0] opcode);
		class_t cls;
		unique case (opcode)
			6'd2:                                   cls = CLASS_INTADD;
			6'd3:                                   cls = CLASS_INTSUB;
			6'd4:                                   cls = CLASS_INTMULT;
			6'd5:                                   cls = CLASS_INTDIV;
			6'd6:                                   cls = CLASS_EFFADDR;
			6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12: cls = CLASS_LOGIC;
			6'd14, 6'd15:                           cls = CLASS_FPSIMPLE;
			6'd16, 6'd17:                           cls = CLASS_FPADD;
			6'd18:                                  cls = CLASS_FPCOMP;
			6'd19:                                  cls = CLASS_FPMULT;
			6'd20:                                  cls = CLASS_FPDIV;
			6'd21, 6'd22, 6'd23, 6'd24,
			6'd25, 6'd26, 6'd27, 6'd28:             cls = CLASS_FPCOMPLEX;
			default:                                cls = CLASS_NONE;
		endcase
		return cls;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/functional_unit_reserver.sv
// Functional unit reservation table: grants units per class, keeps busy times and class counters.
// Depends on fu_res_pkg for widths, codes and the opcode-to-class table.
//
// channel   direction  handshake              payload
// s_axis    in         s_axis_tvalid/tready   tuser: func; tdata: opcode, now, first try, class
// m_axis    out        m_axis_tvalid/tready   tdata: latency, try cycle, counters
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One transaction per cycle sustained while m_axis_tready holds; an accepted transaction passes
// the input register, then the result register. The rate is set by the read-modify-write of one
// class row of busy times and its counters between the input register and the result register.
// Reset clears busy times, counters and the valid flags at once; no clearing pass is needed.
// A stalled result holds in the output register; the input register accepts while it drains.
// cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module functional_unit_reserver
	import fu_res_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	// input stream
	input  wire                    s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire [IN_DATA_W-1:0]    s_axis_tdata,  // opcode[5:0], now[37:6], first_try_cycle[69:38],
	                                              // stat_class[73:70], zero pad
	input  wire [FUNC_W-1:0]       s_axis_tuser,  // func[1:0]
	// result stream
	output logic                   m_axis_tvalid,
	input  wire                    m_axis_tready,
	output logic [OUT_DATA_W-1:0]  m_axis_tdata,  // latency[4:0], try_cycle[36:5],
	                                              // access_count[68:37], denial_count[100:69],
	                                              // waiting_sum[148:101], zero pad
	// configuration writes
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire [CFG_IDX_W-1:0]    cfg_index,
	input  wire [LATS_W-1:0]       cfg_data
);

	// configuration registers
	logic [UNIT_COUNTS_W-1:0] unit_counts_q;
	logic [LATS_W-1:0]        issue_lats_q;
	logic [LATS_W-1:0]        op_lats_q;

	// state
	logic [BUSY_W-1:0] busy_q [CLASS_COUNT][UNITS_PER_CLASS];
	logic [ACC_W-1:0]  accesses_q [CLASS_COUNT];
	logic [ACC_W-1:0]  denials_q [CLASS_COUNT];
	logic [WAIT_W-1:0] waiting_q [CLASS_COUNT];

	// input register
	logic                valid_s1;
	logic [FUNC_W-1:0]   func_s1;
	logic [OPCODE_W-1:0] opcode_s1;
	logic [TIME_W-1:0]   now_s1;
	logic [TIME_W-1:0]   first_s1;
	logic [CLASS_W-1:0]  stat_class_s1;

	// result register
	logic              out_valid_q;
	logic [LAT_W-1:0]  latency_q;
	logic [TIME_W-1:0] try_cycle_q;
	logic [ACC_W-1:0]  access_q;
	logic [ACC_W-1:0]  denial_q;
	logic [WAIT_W-1:0] wait_sum_q;

	// combinational decode
	logic                  fire_s1;
	class_t                cls;
	logic                  has_class;
	logic [ROW_IDX_W-1:0]  cls_row;
	logic [ROW_IDX_W-1:0]  stat_row;
	logic                  stat_ok;
	logic [CNT_W-1:0]      raw_count;
	logic [CNT_W-1:0]      unit_count;
	logic [LAT_W-1:0]      issue_lat;
	logic [LAT_W-1:0]      op_lat;
	logic                  found;
	logic [UNIT_IDX_W-1:0] grant_unit;
	logic [TIME_W-1:0]     try_c;
	logic [TIME_W-1:0]     wait_delta;
	logic [BUSY_W-1:0]     busy_next;
	logic [LAT_W-1:0]      latency_c;
	logic [ACC_W-1:0]      access_c;
	logic [ACC_W-1:0]      denial_c;
	logic [WAIT_W-1:0]     wait_sum_c;
	logic                  busy_any;

	// handshakes
	assign fire_s1       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire_s1;
	assign cfg_ready     = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_counts_q <= '0;
			issue_lats_q  <= LAT_RESET;
			op_lats_q     <= LAT_RESET;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_UNIT_COUNTS: unit_counts_q <= cfg_data[UNIT_COUNTS_W-1:0];
				REG_ISSUE_LATS:  issue_lats_q  <= cfg_data;
				REG_OP_LATS:     op_lats_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			func_s1       <= s_axis_tuser;
			opcode_s1     <= s_axis_tdata[5:0];
			now_s1        <= s_axis_tdata[37:6];
			first_s1      <= s_axis_tdata[69:38];
			stat_class_s1 <= s_axis_tdata[73:70];
		end
	end

	// class decode and per-class configuration fields
	always_comb begin
		cls        = op_class(opcode_s1);
		has_class  = (cls != CLASS_NONE);
		cls_row    = has_class ? ROW_IDX_W'(cls - 4'd1) : '0;
		stat_ok    = (stat_class_s1 >= 4'd1) && (stat_class_s1 <= CLASS_W'(CLASS_COUNT));
		stat_row   = stat_ok ? ROW_IDX_W'(stat_class_s1 - 4'd1) : '0;
		raw_count  = unit_counts_q[cls_row*CNT_W +: CNT_W];
		unit_count = (raw_count > CNT_W'(UNITS_PER_CLASS)) ? CNT_W'(UNITS_PER_CLASS) : raw_count;
		issue_lat  = issue_lats_q[cls_row*LAT_W +: LAT_W];
		op_lat     = op_lats_q[cls_row*LAT_W +: LAT_W];
	end

	// lowest free unit of the class
	always_comb begin
		found      = 1'b0;
		grant_unit = '0;
		for (int i = UNITS_PER_CLASS - 1; i >= 0; i--) begin
			if ((CNT_W'(i) < unit_count) && (busy_q[cls_row][i] <= {1'b0, now_s1})) begin
				found      = 1'b1;
				grant_unit = UNIT_IDX_W'(i);
			end
		end
	end

	// try cycle, wait and new busy time
	always_comb begin
		try_c = first_s1;
		if ((func_s1 == FUNC_RESERVE) && has_class && (first_s1 == '0)) begin
			try_c = now_s1;
		end
		wait_delta = now_s1 - try_c;
		busy_next  = {1'b0, now_s1} + BUSY_W'(issue_lat);
	end

	// result fields
	always_comb begin
		latency_c  = '0;
		access_c   = '0;
		denial_c   = '0;
		wait_sum_c = '0;
		unique case (func_t'(func_s1))
			FUNC_RESERVE: begin
				if (!has_class) begin
					latency_c = LAT_W'(1);
				end else if (found) begin
					latency_c = op_lat;
				end
			end
			FUNC_READ: begin
				if (stat_ok) begin
					access_c   = accesses_q[stat_row];
					denial_c   = denials_q[stat_row];
					wait_sum_c = waiting_q[stat_row];
				end
			end
			default: ;
		endcase
	end

	// busy times and class counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CLASS_COUNT; c++) begin
				for (int u = 0; u < UNITS_PER_CLASS; u++) begin
					busy_q[c][u] <= '0;
				end
				accesses_q[c] <= '0;
				denials_q[c]  <= '0;
				waiting_q[c]  <= '0;
			end
		end else if (fire_s1) begin
			unique case (func_t'(func_s1))
				FUNC_RESERVE: begin
					if (has_class && found) begin
						busy_q[cls_row][grant_unit] <= busy_next;
						accesses_q[cls_row]         <= accesses_q[cls_row] + ACC_W'(1);
						waiting_q[cls_row]          <= waiting_q[cls_row] + WAIT_W'(wait_delta);
					end else if (has_class) begin
						denials_q[cls_row] <= denials_q[cls_row] + ACC_W'(1);
					end
				end
				FUNC_RELEASE: begin
					for (int c = 0; c < CLASS_COUNT; c++) begin
						for (int u = 0; u < UNITS_PER_CLASS; u++) begin
							busy_q[c][u] <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			latency_q   <= latency_c;
			try_cycle_q <= try_c;
			access_q    <= access_c;
			denial_q    <= denial_c;
			wait_sum_q  <= wait_sum_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, wait_sum_q, denial_q, access_q, try_cycle_q, latency_q};

	// any unit still marked busy
	always_comb begin
		busy_any = 1'b0;
		for (int c = 0; c < CLASS_COUNT; c++) begin
			for (int u = 0; u < UNITS_PER_CLASS; u++) begin
				busy_any = busy_any | (busy_q[c][u] != '0);
			end
		end
	end

	// a processed transaction always lands in the result register
	a_fire_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> out_valid_q)
		else $error("processed transaction did not produce a result");

	// a release leaves every unit free
	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && (func_s1 == FUNC_RELEASE)) |=> !busy_any)
		else $error("busy time left after release");

	// only reserve transactions grant a latency
	a_latency_only_reserve: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && (func_s1 != FUNC_RESERVE)) |=> (latency_q == '0))
		else $error("latency granted on a non-reserve transaction");

endmodule

`default_nettype wire
